>>> rtl/assert_macros.svh
// Assertion helpers shared by the geodetic-to-ECEF RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

>>> rtl/gec_pkg.sv
// Shared types, constants and elaboration-time table builders for the
// geodetic-to-ECEF unit. No dependencies.
`default_nettype none

package gec_pkg;

    // Sine/cosine in Q60, range [-2^60, 2^60]
    typedef logic signed [61:0] t_trig;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_EQ_RADIUS  = 2'd0;
    localparam t_cfg_index CFG_FLATTENING = 2'd1;

    // pi in Q61, split into 32-bit halves for the angle scaling
    localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;
    localparam logic [31:0] PI_HI  = 32'h6487_ED51;
    localparam logic [31:0] PI_LO  = 32'h10B4_611A;

    localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;

    localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
    localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

    // Restoring division of a 128-bit value, low 64 quotient bits.
    function automatic logic [63:0] f_udiv(input logic [127:0] num, input logic [63:0] den);
        logic [64:0]  rem;
        logic [127:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 127; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo[63:0];
    endfunction

    // Floor square root of a 128-bit value.
    function automatic logic [63:0] f_isqrt(input logic [127:0] num);
        logic [67:0] remx;
        logic [67:0] trial;
        logic [65:0] rem;
        logic [63:0] root;
        rem  = '0;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            remx  = {rem, num[2*b+1], num[2*b]};
            trial = {2'b00, root, 2'b01};
            if (remx >= trial) begin
                remx = remx - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
            rem = remx[65:0];
        end
        return root;
    endfunction

    // Arctangent of 2^-i in Q60 from the alternating series in Q62.
    function automatic logic signed [63:0] f_atan(input int i);
        logic signed [63:0] acc;
        logic [63:0]        term;
        int                 e;
        acc = '0;
        if (i == 0) begin
            return signed'(PI_Q61 >> 3);
        end
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = f_udiv({64'd0, 64'd1 << (62 - e)}, 64'(2 * k + 1));
                acc  = (k % 2 == 1) ? acc - signed'(term) : acc + signed'(term);
            end
        end
        return (acc + 64'sd2) >>> 2;
    endfunction

    // Inverse CORDIC gain in Q60 for a given stage count.
    function automatic logic signed [63:0] f_inv_gain(input int stages);
        logic [63:0] g;
        logic [63:0] q;
        g = 64'd1 << 60;
        for (int i = 0; i < stages; i++) begin
            if (2 * i < 64) begin
                g = g + (g >> (2 * i));
            end
        end
        q = f_udiv(128'd1 << 122, g);
        return signed'(f_isqrt({6'd0, q, 58'd0}));
    endfunction

endpackage

`default_nettype wire

>>> rtl/gec_mul.sv
// Pipelined signed-magnitude multiplier with a fixed right shift, four stages.
// Built from four 32x32 partial products. Depends on nothing.
`default_nettype none

module gec_mul #(
    parameter int SHIFT = 60
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    logic [63:0]  r_ma, r_mb;
    logic         r_s1, r_s2, r_s3;
    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic [127:0] r_prod;
    logic [63:0]  r_p;
    logic [63:0]  p_shift;

    // Take magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma <= i_a[63] ? 64'd0 - i_a : i_a;
            r_mb <= i_b[63] ? 64'd0 - i_b : i_b;
            r_s1 <= i_a[63] ^ i_b[63];
        end
    end

    // Form partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= r_ma[31:0]  * r_mb[31:0];
            r_lh <= r_ma[31:0]  * r_mb[63:32];
            r_hl <= r_ma[63:32] * r_mb[31:0];
            r_hh <= r_ma[63:32] * r_mb[63:32];
            r_s2 <= r_s1;
        end
    end

    // Sum partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {64'd0, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0}
                    + {r_hh, 64'd0};
            r_s3   <= r_s2;
        end
    end

    // Shift, truncate magnitude, apply sign
    assign p_shift = r_prod[SHIFT +: 64];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_s3 ? 64'd0 - p_shift : p_shift;
        end
    end

    assign o_p = signed'(r_p);

endmodule

`default_nettype wire

>>> rtl/gec_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a binary angle.
// Depends on gec_pkg.
`default_nettype none

module gec_cordic import gec_pkg::*; #(
    parameter int STAGES     = 32,
    parameter int ANGLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_angle,
    output t_trig       o_sin,
    output t_trig       o_cos
);

    localparam int DROP = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << DROP) - 32'd1);
    localparam logic signed [63:0] INV_GAIN = f_inv_gain(STAGES);

    logic [31:0] a_m, a_r, a_mag;
    logic        a_flip;
    logic [63:0] r_pm_hi, r_pm_lo;
    logic        r_neg, r_flip0, r_flip1;
    logic signed [63:0] r_z0;
    logic [63:0] rad;

    logic signed [63:0] r_x [0:STAGES-1];
    logic signed [63:0] r_y [0:STAGES-1];
    logic signed [63:0] r_z [0:STAGES-1];
    logic               r_f [0:STAGES-1];

    logic signed [63:0] cx, cy, ox, oy;
    t_trig r_sin, r_cos;

    // Fold the angle into the right half plane and scale to radians
    always_comb begin
        a_m    = i_angle & ANGLE_MASK;
        a_flip = a_m[31] ^ a_m[30];
        a_r    = a_m ^ {a_flip, 31'd0};
        a_mag  = a_r[31] ? 32'd0 - a_r : a_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm_hi <= a_mag * PI_HI;
            r_pm_lo <= a_mag * PI_LO;
            r_neg   <= a_r[31];
            r_flip0 <= a_flip;
        end
    end

    assign rad = r_pm_hi + (r_pm_lo >> 32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0    <= r_neg ? -signed'(rad) : signed'(rad);
            r_flip1 <= r_flip0;
        end
    end

    // Rotation stages, one micro-rotation each
    for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
        localparam logic signed [63:0] ATAN = f_atan(gi);
        logic signed [63:0] x_in, y_in, z_in;
        logic               f_in;

        if (gi == 0) begin : g_first
            assign x_in = INV_GAIN;
            assign y_in = '0;
            assign z_in = r_z0;
            assign f_in = r_flip1;
        end else begin : g_next
            assign x_in = r_x[gi-1];
            assign y_in = r_y[gi-1];
            assign z_in = r_z[gi-1];
            assign f_in = r_f[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[63]) begin
                    r_x[gi] <= x_in - (y_in >>> gi);
                    r_y[gi] <= y_in + (x_in >>> gi);
                    r_z[gi] <= z_in - ATAN;
                end else begin
                    r_x[gi] <= x_in + (y_in >>> gi);
                    r_y[gi] <= y_in - (x_in >>> gi);
                    r_z[gi] <= z_in + ATAN;
                end
                r_f[gi] <= f_in;
            end
        end
    end

    // Clamp to unit range and undo the half-turn fold
    always_comb begin
        cx = r_x[STAGES-1];
        cy = r_y[STAGES-1];
        if (cx > ONE_Q60) cx = ONE_Q60;
        else if (cx < -ONE_Q60) cx = -ONE_Q60;
        if (cy > ONE_Q60) cy = ONE_Q60;
        else if (cy < -ONE_Q60) cy = -ONE_Q60;
        ox = r_f[STAGES-1] ? -cx : cx;
        oy = r_f[STAGES-1] ? -cy : cy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= ox[61:0];
            r_sin <= oy[61:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

>>> rtl/geodetic_to_ecef_unit.sv
// Geodetic (lon, lat, h) to Earth-centred x, y, z, fully pipelined.
// Throughput: one point per cycle until the 2-entry output buffer fills and stalls it.
// Pipeline: CORDIC, 64-step square root, 62-step divider, split multipliers.
// Synchronous active-low reset clears valid bits and buffer, loads config defaults.
`default_nettype none
`include "assert_macros.svh"

module geodetic_to_ecef_unit import gec_pkg::*; #(
    parameter int CORDIC_STAGES = 32,
    parameter int ANGLE_BITS    = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tdata: longitude[31:0], latitude[63:32], height[95:64]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    // tdata: x_coord[39:0], y_coord[79:40], z_coord[119:80]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  t_cfg_index   i_cfg_index,
    input  logic [32:0]  i_cfg_data
);

    localparam int T0   = CORDIC_STAGES + 3;
    localparam int LTOT = T0 + 146;
    localparam int HD   = T0 + 140;

    // Configuration and derived eccentricity terms
    logic [32:0] r_radius;
    logic [31:0] r_flat;
    logic [65:0] e2_full;
    logic [63:0] r_e2, r_ome2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 33'd6378137000;
            r_flat   <= 32'd14400212;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EQ_RADIUS:  r_radius <= i_cfg_data;
                CFG_FLATTENING: r_flat   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign e2_full = 66'(r_flat) * 66'((34'd1 << 33) - 34'(r_flat));

    always_ff @(posedge i_clk) begin
        r_e2   <= e2_full[65:2];
        r_ome2 <= (64'd1 << 62) - r_e2;
    end

    // Handshake, valid chain and stall control
    logic               en, acc, push, pop;
    logic [LTOT-1:0]    r_vld;
    logic [1:0]         r_cnt;
    logic [119:0]       r_q0, r_q1, out_d;

    assign en            = (r_cnt != 2'd2);
    assign s_axis_tready = i_rst_n & en;
    assign acc           = s_axis_tvalid & s_axis_tready;
    assign push          = en & r_vld[LTOT-1];
    assign pop           = (r_cnt != 2'd0) & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LTOT-2:0], acc};
        end
    end

    // Trig of latitude and longitude
    t_trig sl, cl, sg, cg;

    gec_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_cordic_lat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (s_axis_tdata[63:32]),
        .o_sin   (sl),
        .o_cos   (cl)
    );

    gec_cordic #(.STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_cordic_lon (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (s_axis_tdata[31:0]),
        .o_sin   (sg),
        .o_cos   (cg)
    );

    // Align height and trig values with the radius path
    logic [31:0] r_h_dly  [0:HD-1];
    t_trig       r_cl_dly [0:135];
    t_trig       r_cg_dly [0:139];
    t_trig       r_sg_dly [0:139];
    t_trig       r_sl_dly [0:140];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_dly[0]  <= s_axis_tdata[95:64];
            r_cl_dly[0] <= cl;
            r_cg_dly[0] <= cg;
            r_sg_dly[0] <= sg;
            r_sl_dly[0] <= sl;
            for (int k = 1; k < HD; k++) r_h_dly[k] <= r_h_dly[k-1];
            for (int k = 1; k < 136; k++) r_cl_dly[k] <= r_cl_dly[k-1];
            for (int k = 1; k < 140; k++) begin
                r_cg_dly[k] <= r_cg_dly[k-1];
                r_sg_dly[k] <= r_sg_dly[k-1];
            end
            for (int k = 1; k < 141; k++) r_sl_dly[k] <= r_sl_dly[k-1];
        end
    end

    // sin^2(lat), e2*sin^2(lat) and w = 1 - e2*sin^2(lat)
    logic signed [63:0] s2, t_prod;
    logic [63:0]        r_w;

    gec_mul #(.SHIFT(58)) u_mul_s2 (
        .i_clk (i_clk), .i_en (en),
        .i_a   ({{2{sl[61]}}, sl}), .i_b ({{2{sl[61]}}, sl}),
        .o_p   (s2)
    );

    gec_mul #(.SHIFT(62)) u_mul_t (
        .i_clk (i_clk), .i_en (en),
        .i_a   (signed'(r_e2)), .i_b (s2),
        .o_p   (t_prod)
    );

    always_ff @(posedge i_clk) begin
        if (en) r_w <= (64'd1 << 62) - unsigned'(t_prod);
    end

    // Square root of w in Q62, two radicand bits per stage
    logic [65:0]  r_sq_rem  [0:62];
    logic [127:0] r_sq_rad  [0:62];
    logic [63:0]  r_sq_root [0:63];

    for (genvar gj = 0; gj < 64; gj++) begin : g_sqrt
        logic [65:0]  rem_in;
        logic [63:0]  root_in;
        logic [127:0] rad_in;
        logic [67:0]  remx, trial;
        logic         take;

        if (gj == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {2'b00, r_w, 62'd0};
        end else begin : g_next
            assign rem_in  = r_sq_rem[gj-1];
            assign root_in = r_sq_root[gj-1];
            assign rad_in  = r_sq_rad[gj-1];
        end

        assign remx  = {rem_in, rad_in[127:126]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (remx >= trial);

        always_ff @(posedge i_clk) begin
            if (en) r_sq_root[gj] <= {root_in[62:0], take};
        end

        if (gj < 63) begin : g_carry
            logic [67:0] diff;
            assign diff = remx - trial;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_rem[gj] <= take ? diff[65:0] : remx[65:0];
                    r_sq_rad[gj] <= {rad_in[125:0], 2'b00};
                end
            end
        end
    end

    // N = a * 2^78 / q, one quotient bit per stage, capped on overflow
    logic [63:0] r_dv_rem [0:60];
    logic [63:0] r_dv_den [0:60];
    logic [61:0] r_dv_quo [0:61];
    logic        r_dv_ov  [0:61];

    for (genvar gj = 0; gj < 62; gj++) begin : g_div
        logic [63:0] rem_in, den_in;
        logic [61:0] quo_in;
        logic        ov_in, take;
        logic [64:0] remx, diff;

        if (gj == 0) begin : g_first
            assign rem_in = {15'd0, r_radius, 16'd0};
            assign den_in = r_sq_root[63];
            assign quo_in = '0;
            assign ov_in  = (rem_in >= den_in);
        end else begin : g_next
            assign rem_in = r_dv_rem[gj-1];
            assign den_in = r_dv_den[gj-1];
            assign quo_in = r_dv_quo[gj-1];
            assign ov_in  = r_dv_ov[gj-1];
        end

        assign remx = {rem_in, 1'b0};
        assign take = (remx >= {1'b0, den_in});
        assign diff = remx - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_quo[gj] <= {quo_in[60:0], take};
                r_dv_ov[gj]  <= ov_in;
            end
        end

        if (gj < 61) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[gj] <= take ? diff[63:0] : remx[63:0];
                    r_dv_den[gj] <= den_in;
                end
            end
        end
    end

    // N + h and (1-e2)N + h
    logic [61:0]        n_val, r_n;
    logic signed [63:0] r_ta, r_tb, hq_a, hq_b, bq, c_val;
    logic [31:0]        h_a, h_b;

    assign n_val = r_dv_quo[61] | {62{r_dv_ov[61]}};
    assign h_a   = r_h_dly[T0+134];
    assign h_b   = r_h_dly[T0+139];
    assign hq_a  = signed'({{16{h_a[31]}}, h_a, 16'd0});
    assign hq_b  = signed'({{16{h_b[31]}}, h_b, 16'd0});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n  <= n_val;
            r_ta <= signed'({2'b00, n_val}) + hq_a;
        end
    end

    gec_mul #(.SHIFT(62)) u_mul_bq (
        .i_clk (i_clk), .i_en (en),
        .i_a   (signed'(r_ome2)), .i_b (signed'({2'b00, r_n})),
        .o_p   (bq)
    );

    gec_mul #(.SHIFT(60)) u_mul_c (
        .i_clk (i_clk), .i_en (en),
        .i_a   (r_ta), .i_b ({{2{r_cl_dly[135][61]}}, r_cl_dly[135]}),
        .o_p   (c_val)
    );

    always_ff @(posedge i_clk) begin
        if (en) r_tb <= bq + hq_b;
    end

    // Final products
    logic signed [63:0] x_q, y_q, z_q, r_xd, r_yd;

    gec_mul #(.SHIFT(60)) u_mul_x (
        .i_clk (i_clk), .i_en (en),
        .i_a   (c_val), .i_b ({{2{r_cg_dly[139][61]}}, r_cg_dly[139]}),
        .o_p   (x_q)
    );

    gec_mul #(.SHIFT(60)) u_mul_y (
        .i_clk (i_clk), .i_en (en),
        .i_a   (c_val), .i_b ({{2{r_sg_dly[139][61]}}, r_sg_dly[139]}),
        .o_p   (y_q)
    );

    gec_mul #(.SHIFT(60)) u_mul_z (
        .i_clk (i_clk), .i_en (en),
        .i_a   (r_tb), .i_b ({{2{r_sl_dly[140][61]}}, r_sl_dly[140]}),
        .o_p   (z_q)
    );

    // Round Q16 to millimetres, half up, and saturate to 40 bits
    function automatic logic [39:0] f_to_mm(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = (v + 64'sd32768) >>> 16;
        if (s > OUT_MAX) return OUT_MAX[39:0];
        else if (s < OUT_MIN) return OUT_MIN[39:0];
        else return s[39:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xd  <= x_q;
            r_yd  <= y_q;
            out_d <= {f_to_mm(z_q), f_to_mm(r_yd), f_to_mm(r_xd)};
        end
    end

    // Two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0: begin
                if (push) r_q0 <= out_d;
            end
            2'd1: begin
                if (push && pop) r_q0 <= out_d;
                else if (push) r_q1 <= out_d;
            end
            2'd2: begin
                if (pop) r_q0 <= r_q1;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q0;

    `ASSERT_NEVER(a_buf_bound, r_cnt == 2'd3, "output buffer count out of range")
    `ASSERT_NEVER(a_buf_no_overrun, (r_cnt == 2'd2) && push, "push into full output buffer")
    `ASSERT_CLK(a_accept_enters, acc |=> r_vld[0], "accepted transaction not in pipeline")

endmodule

`default_nettype wire
